FILE: hdl/power_up_sequencer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the power-up sequencer
// Shared helpers for the concurrent checks on the sequencer ports.
// ----------------------------------------------------------------------------
`ifndef POWER_UP_SEQUENCER_UNIT_ASSERT_SVH
`define POWER_UP_SEQUENCER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PUS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("power-up sequencer check failed");

// Check a property on every clock edge, reset included.
`define PUS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("power-up sequencer check failed");

`endif

FILE: hdl/pus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_pkg
// Types and constants shared by the power-up sequencer modules.
// ----------------------------------------------------------------------------
package pus_pkg;

  localparam int unsigned PHASE_W    = 4;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned FAN_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_MS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_HOLD_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DCDC_HOLD_MS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_TIMEOUT_MS = 2'd3;

  // Reset values of the config registers
  localparam logic [TICK_W-1:0] TICK_MS_RST        = 10'd10;
  localparam logic [HOLD_W-1:0] SHORT_HOLD_MS_RST  = 16'd50;
  localparam logic [HOLD_W-1:0] DCDC_HOLD_MS_RST   = 16'd100;
  localparam logic [HOLD_W-1:0] FAN_TIMEOUT_MS_RST = 16'd10000;

  localparam logic [FAN_W-1:0] FAN_ON_PCT  = 7'd100;
  localparam logic [FAN_W-1:0] FAN_OFF_PCT = 7'd0;

  typedef enum logic [PHASE_W-1:0] {
    PH_START    = 4'd0,
    PH_TSSI     = 4'd1,
    PH_PERIPH   = 4'd2,
    PH_ACCUM    = 4'd3,
    PH_MC_PRECH = 4'd4,
    PH_SDC      = 4'd5,
    PH_DCDC     = 4'd6,
    PH_PUMP     = 4'd7,
    PH_FAN      = 4'd8,
    PH_READY    = 4'd9
  } phase_e;

  // Latched enables plus the fan setpoint flag
  typedef struct packed {
    logic tssi;
    logic dcdc;
    logic motor;
    logic accum;
    logic front;
    logic imu;
    logic pump1;
    logic pump2;
    logic sdc;
    logic fan_high;
  } pus_en_t;

  // Status flags of one tick
  typedef struct packed {
    logic front_ctrl_seen;
    logic contactors_open;
    logic motor_ctrl_on;
    logic accum_running;
    logic fans_at_target;
  } pus_flags_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [HOLD_W-1:0] short_hold_ms;
    logic [HOLD_W-1:0] dcdc_hold_ms;
    logic [HOLD_W-1:0] fan_timeout_ms;
  } pus_cfg_t;

  typedef struct packed {
    phase_e  phase;
    pus_en_t en;
  } pus_res_t;

endpackage

FILE: hdl/pus_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_step
// Next-state logic for one tick: phase action, advance test, elapsed update.
// ----------------------------------------------------------------------------
module pus_step #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  pus_pkg::phase_e            phase_i,
  input  logic [COUNTER_BITS-1:0]    elapsed_i,
  input  pus_pkg::pus_en_t           en_i,
  input  pus_pkg::pus_flags_t        flags_i,
  input  pus_pkg::pus_cfg_t          cfg_i,
  output pus_pkg::phase_e            phase_o,
  output logic [COUNTER_BITS-1:0]    elapsed_o,
  output pus_pkg::pus_en_t           en_o
);
  import pus_pkg::*;

  localparam int unsigned CMP_W = (COUNTER_BITS > HOLD_W) ? COUNTER_BITS : HOLD_W;
  localparam int unsigned SUM_W = COUNTER_BITS + 1;

  logic [CMP_W-1:0] elapsed_x;
  logic             gt_short;
  logic             gt_dcdc;
  logic             gt_fan;
  logic             advance;
  logic [SUM_W-1:0] sum;

  // Strict threshold compares
  assign elapsed_x = CMP_W'(elapsed_i);
  assign gt_short  = elapsed_x > CMP_W'(cfg_i.short_hold_ms);
  assign gt_dcdc   = elapsed_x > CMP_W'(cfg_i.dcdc_hold_ms);
  assign gt_fan    = elapsed_x > CMP_W'(cfg_i.fan_timeout_ms);

  // Phase action and advance condition
  always_comb begin
    en_o    = en_i;
    advance = 1'b0;
    unique case (phase_i)
      PH_START: begin
        en_o    = '0;
        advance = gt_short;
      end
      PH_TSSI: begin
        en_o.tssi = 1'b1;
        advance   = gt_short;
      end
      PH_PERIPH: begin
        en_o.front = 1'b1;
        en_o.imu   = 1'b1;
        advance    = gt_short && flags_i.front_ctrl_seen;
      end
      PH_ACCUM: begin
        en_o.accum = 1'b1;
        advance    = flags_i.contactors_open;
      end
      PH_MC_PRECH: begin
        en_o.motor = 1'b1;
        advance    = flags_i.motor_ctrl_on;
      end
      PH_SDC: begin
        en_o.sdc = 1'b1;
        advance  = flags_i.accum_running;
      end
      PH_DCDC: begin
        en_o.dcdc = 1'b1;
        advance   = gt_dcdc;
      end
      PH_PUMP: begin
        en_o.pump1 = 1'b1;
        en_o.pump2 = 1'b1;
        advance    = gt_dcdc;
      end
      PH_FAN: begin
        en_o.fan_high = 1'b1;
        advance       = flags_i.fans_at_target || gt_fan;
      end
      default: begin
        // ready and unused codes: hold
        advance = 1'b0;
      end
    endcase
  end

  // Saturating elapsed counter, cleared on a phase change
  assign sum = {1'b0, elapsed_i} + SUM_W'(cfg_i.tick_ms);

  always_comb begin
    if (advance) begin
      phase_o   = phase_e'(phase_i + PHASE_W'(1));
      elapsed_o = '0;
    end else begin
      phase_o   = phase_i;
      elapsed_o = sum[COUNTER_BITS] ? '1 : sum[COUNTER_BITS-1:0];
    end
  end

endmodule

FILE: hdl/power_up_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_up_sequencer_unit
// Low-voltage power-up sequencer, one status tick in, one phase/enable
// report out.
// ----------------------------------------------------------------------------
// Each accepted tick yields exactly one result in the next cycle, and a new
// tick can be taken every cycle: the whole step is one pass of logic from the
// phase, counter and enable registers into the result register, so the
// throughput is one tick per clock as long as the result side keeps taking
// results. The result register holds one report; input ready drops only
// while that report is waiting and is not being taken in the same cycle.
// Config writes are registered and should be made while no tick is in
// flight.
module power_up_sequencer_unit #(
  parameter int unsigned COUNTER_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pus_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pus_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                front_ctrl_seen_i,
  input  logic                                contactors_open_i,
  input  logic                                motor_ctrl_on_i,
  input  logic                                accum_running_i,
  input  logic                                fans_at_target_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pus_pkg::PHASE_W-1:0]         phase_o,
  output logic                                tssi_en_o,
  output logic                                dcdc_en_o,
  output logic [pus_pkg::FAN_W-1:0]           fan_power_o,
  output logic                                motor_ctrl_en_o,
  output logic                                accum_en_o,
  output logic                                front_ctrl_en_o,
  output logic                                nav_pwr_en_o,
  output logic                                pumps_en_o,
  output logic                                shutdown_loop_en_o
);
  import pus_pkg::*;

  pus_cfg_t                cfg_q;
  phase_e                  phase_q;
  phase_e                  phase_d;
  logic [COUNTER_BITS-1:0] elapsed_q;
  logic [COUNTER_BITS-1:0] elapsed_d;
  pus_en_t                 en_q;
  pus_en_t                 en_d;
  pus_flags_t              flags;
  pus_res_t                res_q;
  logic                    out_valid_q;
  logic                    in_xfer;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_ms        <= TICK_MS_RST;
      cfg_q.short_hold_ms  <= SHORT_HOLD_MS_RST;
      cfg_q.dcdc_hold_ms   <= DCDC_HOLD_MS_RST;
      cfg_q.fan_timeout_ms <= FAN_TIMEOUT_MS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TICK_MS:        cfg_q.tick_ms        <= cfg_wdata_i[TICK_W-1:0];
        CFG_SHORT_HOLD_MS:  cfg_q.short_hold_ms  <= cfg_wdata_i;
        CFG_DCDC_HOLD_MS:   cfg_q.dcdc_hold_ms   <= cfg_wdata_i;
        CFG_FAN_TIMEOUT_MS: cfg_q.fan_timeout_ms <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input transfer whenever the result slot is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign flags = '{
    front_ctrl_seen: front_ctrl_seen_i,
    contactors_open: contactors_open_i,
    motor_ctrl_on:   motor_ctrl_on_i,
    accum_running:   accum_running_i,
    fans_at_target:  fans_at_target_i
  };

  pus_step #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_step (
    .phase_i   (phase_q),
    .elapsed_i (elapsed_q),
    .en_i      (en_q),
    .flags_i   (flags),
    .cfg_i     (cfg_q),
    .phase_o   (phase_d),
    .elapsed_o (elapsed_d),
    .en_o      (en_d)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      elapsed_q <= '0;
      en_q      <= '0;
    end else if (in_xfer) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      en_q      <= en_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (in_xfer) begin
      res_q.phase <= phase_d;
      res_q.en    <= en_d;
    end
  end

  // Output fields
  assign out_valid_o        = out_valid_q;
  assign phase_o            = res_q.phase;
  assign tssi_en_o          = res_q.en.tssi;
  assign dcdc_en_o          = res_q.en.dcdc;
  assign fan_power_o        = res_q.en.fan_high ? FAN_ON_PCT : FAN_OFF_PCT;
  assign motor_ctrl_en_o    = res_q.en.motor;
  assign accum_en_o         = res_q.en.accum;
  assign front_ctrl_en_o    = res_q.en.front;
  assign nav_pwr_en_o       = res_q.en.imu;
  assign pumps_en_o         = res_q.en.pump1 & res_q.en.pump2;
  assign shutdown_loop_en_o = res_q.en.sdc;

endmodule

FILE: hdl/pus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pus_checker
// Port-level checks on the power-up sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "power_up_sequencer_unit_assert.svh"

module pus_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [pus_pkg::PHASE_W-1:0]   phase_o,
  input logic                          tssi_en_o,
  input logic                          dcdc_en_o,
  input logic [pus_pkg::FAN_W-1:0]     fan_power_o,
  input logic                          motor_ctrl_en_o,
  input logic                          accum_en_o,
  input logic                          front_ctrl_en_o,
  input logic                          nav_pwr_en_o,
  input logic                          pumps_en_o,
  input logic                          shutdown_loop_en_o
);
  import pus_pkg::*;

  logic all_on;
  logic any_on;

  assign all_on  = tssi_en_o && dcdc_en_o && motor_ctrl_en_o && accum_en_o &&
                   front_ctrl_en_o && nav_pwr_en_o && pumps_en_o &&
                   shutdown_loop_en_o && (fan_power_o == FAN_ON_PCT);
  assign any_on  = tssi_en_o || dcdc_en_o || motor_ctrl_en_o || accum_en_o ||
                   front_ctrl_en_o || nav_pwr_en_o || pumps_en_o ||
                   shutdown_loop_en_o || (fan_power_o != FAN_OFF_PCT);

  // A pending result holds until its transfer
  `PUS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // Input is only back-pressured by a waiting result
  `PUS_ASSERT_ALWAYS(a_ready_backpressure, clk_i, !in_ready_o |-> out_valid_o)

  // Phase steps forward by one at most between reports
  `PUS_ASSERT(a_phase_step, clk_i, rst_ni, 1'b1 |=> (phase_o == $past(phase_o)) || (phase_o == $past(phase_o) + 4'd1))

  // Start phase reports nothing enabled; ready reports everything on
  `PUS_ASSERT(a_start_off, clk_i, rst_ni, out_valid_o && (phase_o == PH_START) |-> !any_on)
  `PUS_ASSERT(a_ready_on, clk_i, rst_ni, out_valid_o && (phase_o == PH_READY) |-> all_on)

endmodule

bind power_up_sequencer_unit pus_checker u_pus_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .phase_o            (phase_o),
  .tssi_en_o          (tssi_en_o),
  .dcdc_en_o          (dcdc_en_o),
  .fan_power_o        (fan_power_o),
  .motor_ctrl_en_o    (motor_ctrl_en_o),
  .accum_en_o         (accum_en_o),
  .front_ctrl_en_o    (front_ctrl_en_o),
  .nav_pwr_en_o       (nav_pwr_en_o),
  .pumps_en_o         (pumps_en_o),
  .shutdown_loop_en_o (shutdown_loop_en_o)
);

FILE: test/power_up_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_up_sequencer_unit_tb
// Drives status ticks through one full power-up walk and checks every
// phase/enable report against a cycle-free predictor of the sequencer. The
// walk is split into tests that retune the hold times between them: reset
// values, strict hold boundaries, the flag-gated phases under back-pressure,
// a zero tick, counter saturation, the fan phase and the final ready phase.
// ----------------------------------------------------------------------------
module power_up_sequencer_unit_tb;
  import pus_pkg::*;

  localparam int unsigned   CNT_BITS    = 16;
  localparam longint unsigned CNT_MAX   = (64'd1 << CNT_BITS) - 1;
  localparam int unsigned   CYCLE_LIMIT = 100000;

  // One phase/enable report as it leaves the block
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               tssi;
    logic               dcdc;
    logic [FAN_W-1:0]   fan_power;
    logic               motor;
    logic               accum;
    logic               front;
    logic               imu;
    logic               pumps;
    logic               sdc;
  } report_t;

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i        = CFG_TICK_MS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i        = '0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_ready_o;
  logic                  front_ctrl_seen_i  = 1'b0;
  logic                  contactors_open_i  = 1'b0;
  logic                  motor_ctrl_on_i    = 1'b0;
  logic                  accum_running_i    = 1'b0;
  logic                  fans_at_target_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i        = 1'b0;
  logic [PHASE_W-1:0]    phase_o;
  logic                  tssi_en_o;
  logic                  dcdc_en_o;
  logic [FAN_W-1:0]      fan_power_o;
  logic                  motor_ctrl_en_o;
  logic                  accum_en_o;
  logic                  front_ctrl_en_o;
  logic                  nav_pwr_en_o;
  logic                  pumps_en_o;
  logic                  shutdown_loop_en_o;

  // Predicted sequencer state and register copy
  logic [PHASE_W-1:0] phase_q;
  longint unsigned    elapsed_q;
  pus_en_t            en_q;
  pus_cfg_t           cfg_q;

  report_t     expected_reports[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  bit          tx_idle_en   = 1'b0;
  bit          rx_idle_en   = 1'b0;
  int unsigned rx_hold_len  = 0;

  power_up_sequencer_unit #(
    .COUNTER_BITS(CNT_BITS)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .front_ctrl_seen_i  (front_ctrl_seen_i),
    .contactors_open_i  (contactors_open_i),
    .motor_ctrl_on_i    (motor_ctrl_on_i),
    .accum_running_i    (accum_running_i),
    .fans_at_target_i   (fans_at_target_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .phase_o            (phase_o),
    .tssi_en_o          (tssi_en_o),
    .dcdc_en_o          (dcdc_en_o),
    .fan_power_o        (fan_power_o),
    .motor_ctrl_en_o    (motor_ctrl_en_o),
    .accum_en_o         (accum_en_o),
    .front_ctrl_en_o    (front_ctrl_en_o),
    .nav_pwr_en_o       (nav_pwr_en_o),
    .pumps_en_o         (pumps_en_o),
    .shutdown_loop_en_o (shutdown_loop_en_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One tick: phase action, advance decision, counter update, report.
  function automatic report_t step_sequencer(input pus_flags_t f);
    report_t         r;
    logic            adv;
    longint unsigned sum;
    adv = 1'b0;
    case (phase_q)
      PH_START: begin
        en_q = '0;
        adv  = elapsed_q > cfg_q.short_hold_ms;
      end
      PH_TSSI: begin
        en_q.tssi = 1'b1;
        adv       = elapsed_q > cfg_q.short_hold_ms;
      end
      PH_PERIPH: begin
        en_q.front = 1'b1;
        en_q.imu   = 1'b1;
        adv        = (elapsed_q > cfg_q.short_hold_ms) && f.front_ctrl_seen;
      end
      PH_ACCUM: begin
        en_q.accum = 1'b1;
        adv        = f.contactors_open;
      end
      PH_MC_PRECH: begin
        en_q.motor = 1'b1;
        adv        = f.motor_ctrl_on;
      end
      PH_SDC: begin
        en_q.sdc = 1'b1;
        adv      = f.accum_running;
      end
      PH_DCDC: begin
        en_q.dcdc = 1'b1;
        adv       = elapsed_q > cfg_q.dcdc_hold_ms;
      end
      PH_PUMP: begin
        en_q.pump1 = 1'b1;
        en_q.pump2 = 1'b1;
        adv        = elapsed_q > cfg_q.dcdc_hold_ms;
      end
      PH_FAN: begin
        en_q.fan_high = 1'b1;
        adv           = f.fans_at_target || (elapsed_q > cfg_q.fan_timeout_ms);
      end
      default: ;
    endcase

    // Counter restarts on a phase change, else accumulates and saturates
    if (adv) begin
      phase_q   = phase_q + 1'b1;
      elapsed_q = 0;
    end else begin
      sum       = elapsed_q + cfg_q.tick_ms;
      elapsed_q = (sum > CNT_MAX) ? CNT_MAX : sum;
    end

    r.phase     = phase_q;
    r.tssi      = en_q.tssi;
    r.dcdc      = en_q.dcdc;
    r.fan_power = en_q.fan_high ? FAN_ON_PCT : FAN_OFF_PCT;
    r.motor     = en_q.motor;
    r.accum     = en_q.accum;
    r.front     = en_q.front;
    r.imu       = en_q.imu;
    r.pumps     = en_q.pump1 & en_q.pump2;
    r.sdc       = en_q.sdc;
    return r;
  endfunction

  // Random flags, with the advance flag of the current phase forced to gate
  function automatic pus_flags_t gated_flags(input logic gate);
    logic [4:0] raw;
    pus_flags_t f;
    raw = 5'($urandom_range(0, 31));
    f   = raw;
    case (phase_q)
      PH_PERIPH:   f.front_ctrl_seen = gate;
      PH_ACCUM:    f.contactors_open = gate;
      PH_MC_PRECH: f.motor_ctrl_on   = gate;
      PH_SDC:      f.accum_running   = gate;
      PH_FAN:      f.fans_at_target  = gate;
      default: ;
    endcase
    return f;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offer one tick, hold it until the transfer, then predict its report
  task automatic send_tick(input pus_flags_t f);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    front_ctrl_seen_i <= f.front_ctrl_seen;
    contactors_open_i <= f.contactors_open;
    motor_ctrl_on_i   <= f.motor_ctrl_on;
    accum_running_i   <= f.accum_running;
    fans_at_target_i  <= f.fans_at_target;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_reports.push_back(step_sequencer(f));
  endtask

  // Stop offering and wait until every report is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers back to back; block must be idle
  task automatic load_settings(input logic [CFG_DATA_W-1:0] tick,
                               input logic [CFG_DATA_W-1:0] short_hold,
                               input logic [CFG_DATA_W-1:0] dcdc_hold,
                               input logic [CFG_DATA_W-1:0] fan_timeout);
    logic [CFG_IDX_W-1:0]  idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{CFG_TICK_MS, CFG_SHORT_HOLD_MS, CFG_DCDC_HOLD_MS, CFG_FAN_TIMEOUT_MS};
    val = '{tick, short_hold, dcdc_hold, fan_timeout};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      case (idx[i])
        CFG_TICK_MS:        cfg_q.tick_ms        = val[i][TICK_W-1:0];
        CFG_SHORT_HOLD_MS:  cfg_q.short_hold_ms  = val[i][HOLD_W-1:0];
        CFG_DCDC_HOLD_MS:   cfg_q.dcdc_hold_ms   = val[i][HOLD_W-1:0];
        CFG_FAN_TIMEOUT_MS: cfg_q.fan_timeout_ms = val[i][HOLD_W-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls per report, plus one-off long hold-offs
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        gap         = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        gap = rx_idle_en ? $urandom_range(0, 15) : 0;
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin : result_check
    report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("report transfer with no tick pending");
      end else begin
        want = expected_reports.pop_front();
        check_field("phase", 8'(phase_o), 8'(want.phase));
        check_field("tssi_en", 8'(tssi_en_o), 8'(want.tssi));
        check_field("dcdc_en", 8'(dcdc_en_o), 8'(want.dcdc));
        check_field("fan_power", 8'(fan_power_o), 8'(want.fan_power));
        check_field("motor_ctrl_en", 8'(motor_ctrl_en_o), 8'(want.motor));
        check_field("accum_en", 8'(accum_en_o), 8'(want.accum));
        check_field("front_ctrl_en", 8'(front_ctrl_en_o), 8'(want.front));
        check_field("nav_pwr_en", 8'(nav_pwr_en_o), 8'(want.imu));
        check_field("pumps_en", 8'(pumps_en_o), 8'(want.pumps));
        check_field("shutdown_loop_en", 8'(shutdown_loop_en_o), 8'(want.sdc));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset register values: 10 ms ticks, start leaves once past 50 ms
  task automatic test_reset_defaults();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 12; i++) send_tick(gated_flags(1'b0));
  endtask

  // Strict thresholds and the front controller gate in the periph phase
  task automatic test_hold_boundaries();
    int n;
    drain();
    load_settings(16'd1000, 16'd1000, 16'd0, 16'd0);
    n = 0;
    while (phase_q == PH_TSSI && n < 6) begin
      send_tick(n[0] ? 5'h1F : 5'h00);
      n++;
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    // seen too early, seen at the threshold, late but unseen, then seen
    send_tick(gated_flags(1'b1));
    send_tick(gated_flags(1'b1));
    send_tick(gated_flags(1'b0));
    send_tick(gated_flags(1'b1));
  endtask

  // Accum, precharge and shutdown loop phases, each held by its flag for a
  // while; the accum phase starts with a long result-side hold-off.
  task automatic test_gated_phases();
    int unsigned n;
    logic [PHASE_W-1:0] ph;
    drain();
    load_settings(16'hFFFF, 16'd0, 16'hFFFE, 16'hFFFE);
    rx_hold_len = 300;
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b1;
    for (int p = 0; p < 3; p++) begin
      ph = phase_q;
      n  = $urandom_range(70, 100);
      for (int unsigned i = 0; i < n && phase_q == ph; i++) begin
        if (i % 25 == 24 && !(p == 0 && i < 30)) begin
          tx_idle_en = ($urandom_range(0, 3) != 0);
          rx_idle_en = ($urandom_range(0, 3) != 0);
        end
        if (p == 0 && i == 30) tx_idle_en = 1'b1;
        send_tick(gated_flags(1'b0));
      end
      send_tick(gated_flags(1'b1));
    end
  endtask

  // A zero tick freezes the counter, so dcdc with zero hold never leaves
  task automatic test_zero_tick();
    int n;
    drain();
    load_settings(16'd0, 16'd0, 16'd0, 16'd3000);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < 20; i++) send_tick(gated_flags(1'b0));
    drain();
    load_settings(16'd1, 16'd0, 16'd0, 16'd3000);
    n = 0;
    while (phase_q == PH_DCDC && n < 5) begin
      send_tick(gated_flags(1'b0));
      n++;
    end
  endtask

  // Pump phase with the widest hold: only a saturated counter exceeds it.
  // The tick write also sets bits above the register width.
  task automatic test_counter_saturation();
    int n;
    drain();
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFE, 16'd3000);
    n = 0;
    while (phase_q == PH_PUMP && n < 80) begin
      send_tick(gated_flags(1'b0));
      n++;
    end
  endtask

  // Fan phase leaves on the setpoint flag or on the timeout
  task automatic test_fan_phase();
    int n;
    drain();
    load_settings(16'd1000, 16'd0, 16'd0, 16'd3000);
    n = 0;
    while (phase_q == PH_FAN && n < 10) begin
      send_tick(gated_flags($urandom_range(0, 9) == 0));
      n++;
    end
  endtask

  // Ready holds whatever the flags say
  task automatic test_ready_phase();
    logic [4:0] raw;
    for (int i = 0; i < 80; i++) begin
      raw = 5'($urandom_range(0, 31));
      send_tick(raw);
    end
  endtask

  initial begin
    phase_q              = PH_START;
    elapsed_q            = 0;
    en_q                 = '0;
    cfg_q.tick_ms        = TICK_MS_RST;
    cfg_q.short_hold_ms  = SHORT_HOLD_MS_RST;
    cfg_q.dcdc_hold_ms   = DCDC_HOLD_MS_RST;
    cfg_q.fan_timeout_ms = FAN_TIMEOUT_MS_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_hold_boundaries();
    test_gated_phases();
    test_zero_tick();
    test_counter_saturation();
    test_fan_phase();
    test_ready_phase();
    drain();

    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
